/* rtl/sliding_window_emitter_core_macros.svh */
// ----------------------------------------------------------------------------
// Sliding window emitter assertion macros
// Shared concurrent assertion forms for the emitter RTL.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_EMITTER_CORE_MACROS_SVH
`define SLIDING_WINDOW_EMITTER_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset
`define SWE_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("swe: same-cycle check failed");

// Next-cycle implication, disabled during reset
`define SWE_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("swe: next-cycle check failed");

`endif

/* rtl/swe_pkg.sv */
// ----------------------------------------------------------------------------
// Sliding window emitter package
// Field widths, command codes and parameter defaults.
// ----------------------------------------------------------------------------
package swe_pkg;

   // Parameter defaults
   localparam int MAX_WINDOW_DEF   = 32;
   localparam int ELEMENT_BITS_DEF = 32;

   // Fixed field widths
   localparam int CMD_W  = 2;
   localparam int ELEM_W = 32;
   localparam int WS_W   = 6;
   localparam int WIDE_W = 64;

   // Command codes
   localparam logic [CMD_W-1:0] CMD_APPEND = 2'd0;
   localparam logic [CMD_W-1:0] CMD_EMIT   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

endpackage

/* rtl/swe_req_if.sv */
// ----------------------------------------------------------------------------
// Sliding window emitter request channel
// Valid/ready channel carrying one command beat.
// ----------------------------------------------------------------------------
interface swe_req_if;
   logic                           valid;
   logic                           ready;
   logic [swe_pkg::CMD_W-1:0]      cmd;
   logic [swe_pkg::ELEM_W-1:0]     element;

   modport source (output valid, output cmd, output element, input ready);
   modport sink   (input valid, input cmd, input element, output ready);
endinterface

/* rtl/swe_rsp_if.sv */
// ----------------------------------------------------------------------------
// Sliding window emitter response channel
// Valid/ready channel carrying one emitted element beat.
// ----------------------------------------------------------------------------
interface swe_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [swe_pkg::ELEM_W-1:0]     element_out;
   logic                           last;
   logic                           empty_res;

   modport source (output valid, output element_out, output last, output empty_res,
                   input ready);
   modport sink   (input valid, input element_out, input last, input empty_res,
                   output ready);
endinterface

/* rtl/swe_ram.sv */
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data held until next read.
// ----------------------------------------------------------------------------
module swe_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic                                        rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read, holds when idle
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/sliding_window_emitter_core.sv */
// ----------------------------------------------------------------------------
// Sliding window emitter core
// Ring store of recent elements; emits the full window oldest first.
// ----------------------------------------------------------------------------
// Each request beat is taken while the core is idle. Append and clear update
// the ring pointers as the beat is taken and leave the core idle. An emit, or
// an append that fills the window, then streams its N stored elements through
// the store's single read port at one beat per cycle while the output slot is
// free (rsp_ch.ready may stall it); an empty emit returns one beat flagged
// empty. The read data register of the store is the output stage, so the last
// beat of a window may wait on rsp_ch.ready while the next request is already
// being accepted. The user must write the window size register from csr_wdata
// with csr_we only while the core is idle; the core does not enforce this.
// Zero acts as one and values above MAX_WINDOW saturate.
// ----------------------------------------------------------------------------
`include "sliding_window_emitter_core_macros.svh"

module sliding_window_emitter_core #(
   parameter int MAX_WINDOW   = swe_pkg::MAX_WINDOW_DEF,
   parameter int ELEMENT_BITS = swe_pkg::ELEMENT_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_we,
   input  logic [swe_pkg::WS_W-1:0] csr_wdata,
   swe_req_if.sink                  req_ch,
   swe_rsp_if.source                rsp_ch
);

   localparam int PTR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int CNT_W = $clog2(MAX_WINDOW + 1);
   localparam int SUM_W = CNT_W + 1;
   localparam int WSX_W = swe_pkg::WS_W + 1;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_EMIT = 2'b10
   } state_type;

   // Ring index add with single wrap (operands sum below twice the depth)
   function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] base,
                                                 input logic [CNT_W-1:0] ofs);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(base) + SUM_W'(ofs);
      if (sum >= SUM_W'(MAX_WINDOW)) begin
         sum = sum - SUM_W'(MAX_WINDOW);
      end
      return sum[PTR_W-1:0];
   endfunction

   // Registers
   state_type                state_ff, state_in;
   logic [swe_pkg::WS_W-1:0] window_size_ff;
   logic [PTR_W-1:0]         oldest_ff, oldest_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [PTR_W-1:0]         rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]         remain_ff, remain_in;
   logic                     empty_pend_ff, empty_pend_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     last_ff, last_in;
   logic                     rsp_empty_ff, rsp_empty_in;

   // Datapath
   logic                     req_fire;
   logic                     slot_free;
   logic [WSX_W-1:0]         ws_ext;
   logic [WSX_W-1:0]         win_sat;
   logic [CNT_W-1:0]         win_eff;
   logic                     full;
   logic [PTR_W-1:0]         base_ptr;
   logic [CNT_W-1:0]         base_cnt;
   logic [CNT_W-1:0]         app_cnt;
   logic                     win_hit;
   logic [PTR_W-1:0]         trim_ptr;
   logic                     wr_en;
   logic [PTR_W-1:0]         wr_addr;
   logic [swe_pkg::WIDE_W-1:0] wr_wide;
   logic [ELEMENT_BITS-1:0]  wr_data;
   logic                     rd_en;
   logic [ELEMENT_BITS-1:0]  rd_data;
   logic [swe_pkg::WIDE_W-1:0] rd_wide;

   assign req_fire  = req_ch.valid && req_ch.ready;
   assign slot_free = !rsp_valid_ff || rsp_ch.ready;

   // Effective window: zero acts as one, saturate at store depth
   assign ws_ext = {1'b0, window_size_ff};
   always_comb begin
      priority if (ws_ext == '0) begin
         win_sat = WSX_W'(1);
      end else if (ws_ext > WSX_W'(MAX_WINDOW)) begin
         win_sat = WSX_W'(MAX_WINDOW);
      end else begin
         win_sat = ws_ext;
      end
   end
   assign win_eff = win_sat[CNT_W-1:0];

   // Append: drop oldest when full, write at tail, trim to window
   assign full     = (count_ff == CNT_W'(MAX_WINDOW));
   assign base_ptr = full ? ring_add(oldest_ff, CNT_W'(1)) : oldest_ff;
   assign base_cnt = full ? (count_ff - CNT_W'(1)) : count_ff;
   assign wr_addr  = ring_add(base_ptr, base_cnt);
   assign app_cnt  = base_cnt + CNT_W'(1);
   assign win_hit  = (app_cnt >= win_eff);
   assign trim_ptr = ring_add(base_ptr, app_cnt - win_eff);

   assign wr_en   = req_fire && (req_ch.cmd == swe_pkg::CMD_APPEND);
   assign wr_wide = swe_pkg::WIDE_W'(req_ch.element);
   assign wr_data = wr_wide[ELEMENT_BITS-1:0];

   // Next-state logic
   always_comb begin
      state_in      = state_ff;
      oldest_in     = oldest_ff;
      count_in      = count_ff;
      rd_ptr_in     = rd_ptr_ff;
      remain_in     = remain_ff;
      empty_pend_in = empty_pend_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      last_in       = last_ff;
      rsp_empty_in  = rsp_empty_ff;
      rd_en         = 1'b0;

      // Command beat
      if (req_fire) begin
         unique case (req_ch.cmd)
            swe_pkg::CMD_APPEND: begin
               if (win_hit) begin
                  oldest_in     = trim_ptr;
                  count_in      = win_eff;
                  rd_ptr_in     = trim_ptr;
                  remain_in     = win_eff;
                  empty_pend_in = 1'b0;
                  state_in      = ST_EMIT;
               end else begin
                  oldest_in = base_ptr;
                  count_in  = app_cnt;
               end
            end
            swe_pkg::CMD_EMIT: begin
               rd_ptr_in     = oldest_ff;
               remain_in     = count_ff;
               empty_pend_in = (count_ff == '0);
               state_in      = ST_EMIT;
            end
            swe_pkg::CMD_CLEAR: begin
               oldest_in = '0;
               count_in  = '0;
            end
            default: begin
            end
         endcase
      end

      // Stream one beat per cycle while the output slot frees up
      if ((state_ff == ST_EMIT) && slot_free) begin
         rsp_valid_in = 1'b1;
         if (empty_pend_ff) begin
            last_in      = 1'b1;
            rsp_empty_in = 1'b1;
            state_in     = ST_IDLE;
         end else begin
            rd_en        = 1'b1;
            last_in      = (remain_ff == CNT_W'(1));
            rsp_empty_in = 1'b0;
            rd_ptr_in    = ring_add(rd_ptr_ff, CNT_W'(1));
            remain_in    = remain_ff - CNT_W'(1);
            if (remain_ff == CNT_W'(1)) begin
               state_in = ST_IDLE;
            end
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         window_size_ff <= '0;
         oldest_ff      <= '0;
         count_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         oldest_ff    <= oldest_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            window_size_ff <= csr_wdata;
         end
      end
   end

   // Emission bookkeeping and beat flags
   always_ff @(posedge clock) begin
      rd_ptr_ff     <= rd_ptr_in;
      remain_ff     <= remain_in;
      empty_pend_ff <= empty_pend_in;
      last_ff       <= last_in;
      rsp_empty_ff  <= rsp_empty_in;
   end

   // Element store
   swe_ram #(
      .WIDTH (ELEMENT_BITS),
      .DEPTH (MAX_WINDOW)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_ptr_ff),
      .rd_data (rd_data)
   );

   // Response channel
   assign rd_wide            = swe_pkg::WIDE_W'(rd_data);
   assign req_ch.ready       = (state_ff == ST_IDLE);
   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.element_out = rsp_empty_ff ? '0 : rd_wide[swe_pkg::ELEM_W-1:0];
   assign rsp_ch.last        = last_ff;
   assign rsp_ch.empty_res   = rsp_empty_ff;

   // Checks
   `SWE_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(MAX_WINDOW))
   `SWE_ASSERT_IMP(a_emit_remain, clock, reset, (state_ff == ST_EMIT) && !empty_pend_ff, remain_ff != '0)
   `SWE_ASSERT_IMP(a_empty_last, clock, reset, rsp_valid_ff && rsp_empty_ff, last_ff)
   `SWE_ASSERT_NXT(a_window_trim, clock, reset, wr_en && win_hit, (count_ff == $past(win_eff)) && (state_ff == ST_EMIT))

endmodule
